>>> hdl/mwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 word hash package
// Shared constants and types for the front end, the item queue and the
// hash back end.
// ----------------------------------------------------------------------------
package mwh_pkg;

  // Mixing multiplier and shift amounts of the 32-bit MurmurHash2.
  localparam logic [31:0] MIX_MUL      = 32'h5bd1_e995;
  localparam int          PREMIX_SHIFT = 24;
  localparam int          FIN_SHIFT_A  = 13;
  localparam int          FIN_SHIFT_B  = 15;

  // Seed register value after reset.
  localparam logic [31:0] SEED_RESET = 32'd1234567;

  // Queue between front end and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // What the back end does with a word.
  typedef enum logic [1:0] {
    KIND_NONE,   // no bytes: hash unchanged
    KIND_FULL,   // premixed word folded in as h*M ^ k
    KIND_TAIL    // partial word XORed in, then multiplied
  } kind_t;

  // One classified word on its way to the back end.
  typedef struct packed {
    kind_t       kind;
    logic        first;
    logic        last;
    logic [31:0] init_hash;  // seed ^ key length, used when first is set
    logic [31:0] operand;    // premixed word or masked tail bytes
  } qitem_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> hdl/mwh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 front end
// Accepts input words, classifies them by byte count and runs the word
// premix in two register stages before handing them to the queue.
// ----------------------------------------------------------------------------
module mwh_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     seed,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     data_word,
  input  logic [2:0]      valid_bytes,
  input  logic            first_of_key,
  input  logic            last_of_key,
  input  logic [31:0]     key_length,
  input  mwh_pkg::qstat_t qstat,
  output logic            push,
  output mwh_pkg::qitem_t push_item
);
  import mwh_pkg::*;

  logic        s1_valid;
  qitem_t      s1;
  logic        s2_valid;
  qitem_t      s2;
  logic        s1_ready;
  logic        s2_ready;
  qitem_t      s1_next;
  qitem_t      s2_next;
  logic [31:0] tail_mask;
  logic [31:0] mixed;

  // Stall chain: each stage takes a word when empty or when it drains.
  assign s2_ready = !s2_valid || !qstat.full;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign push      = s2_valid && !qstat.full;
  assign push_item = s2;

  // Classify the word and start the premix with the first multiply.
  always_comb begin
    case (valid_bytes)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
    s1_next.first     = first_of_key;
    s1_next.last      = last_of_key;
    s1_next.init_hash = seed ^ key_length;
    case (valid_bytes) inside
      3'd0: begin
        s1_next.kind    = KIND_NONE;
        s1_next.operand = data_word;
      end
      [3'd4:3'd7]: begin
        s1_next.kind    = KIND_FULL;
        s1_next.operand = data_word * MIX_MUL;
      end
      default: begin
        s1_next.kind    = KIND_TAIL;
        s1_next.operand = data_word & tail_mask;
      end
    endcase
  end

  // Finish the premix of full words: xor-shift, then the second multiply.
  always_comb begin
    mixed   = s1.operand ^ (s1.operand >> PREMIX_SHIFT);
    s2_next = s1;
    if (s1.kind == KIND_FULL) begin
      s2_next.operand = mixed * MIX_MUL;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1 <= s1_next;
    end
    if (s2_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

>>> hdl/mwh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 item queue
// Short first-in first-out queue that decouples the front end from the
// hash back end.
// ----------------------------------------------------------------------------
module mwh_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mwh_pkg::qitem_t push_item,
  input  logic            pop,
  output mwh_pkg::qitem_t pop_item,
  output mwh_pkg::qstat_t qstat
);
  import mwh_pkg::*;

  qitem_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign qstat.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_item    = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hdl/mwh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 back end
// Folds queued words into the running hash, one per cycle when not stalled,
// and runs the finalizer in two register stages into the output register.
// ----------------------------------------------------------------------------
module mwh_back (
  input  logic            clk,
  input  logic            rst,
  input  mwh_pkg::qstat_t qstat,
  input  mwh_pkg::qitem_t pop_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     hash_value
);
  import mwh_pkg::*;

  logic [31:0] running_hash;
  logic [31:0] base_hash;
  logic [31:0] hash_next;
  logic [31:0] fin_pre;
  logic        f1_valid;
  logic [31:0] f1;
  logic        out_slot;
  logic        f1_advance;

  // Finalizer stall chain.
  assign out_slot   = !out_valid || out_ready;
  assign f1_advance = f1_valid && out_slot;
  assign pop        = !qstat.empty && (!f1_valid || out_slot);

  // One step of the running-hash loop.
  always_comb begin
    base_hash = pop_item.first ? pop_item.init_hash : running_hash;
    case (pop_item.kind)
      KIND_FULL: hash_next = (base_hash * MIX_MUL) ^ pop_item.operand;
      KIND_TAIL: hash_next = (base_hash ^ pop_item.operand) * MIX_MUL;
      default:   hash_next = base_hash;
    endcase
    fin_pre = hash_next ^ (hash_next >> FIN_SHIFT_A);
  end

  // Control state: running hash and stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      f1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        running_hash <= hash_next;
      end
      if (pop && pop_item.last) begin
        f1_valid <= 1'b1;
      end else if (f1_advance) begin
        f1_valid <= 1'b0;
      end
      if (out_slot) begin
        out_valid <= f1_valid;
      end
    end
  end

  // Finalizer: first xor-shift registered, then multiply and last xor-shift.
  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      f1 <= fin_pre;
    end
    if (f1_advance) begin
      hash_value <= (f1 * MIX_MUL) ^ ((f1 * MIX_MUL) >> FIN_SHIFT_B);
    end
  end

endmodule

>>> hdl/murmur2_word_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 word hash
// Computes the 32-bit MurmurHash2 of keys delivered as little-endian words.
// ----------------------------------------------------------------------------
// The block takes one word per cycle unless the output stalls, and gives one
// hash per key on the word marked last. A word passes the two premix stages
// and waits in a four-entry queue. It is folded into the running hash as it
// leaves the queue, and the last word of a key enters the first of two
// finalizer stages at once, then the output register. The sustained rate is
// set by the running-hash loop in the back end, which does one multiply and
// one XOR per word. The user must write the seed through the configuration
// channel only while no key is in flight; the block does not enforce it.
module murmur2_word_hash (
  input  logic        clk,
  input  logic        rst,
  // Configuration: seed.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] data_word, [34:32] valid_bytes, [66:35] key_length, rest zero
  input  logic [71:0] s_axis_tdata,
  // [0] first_of_key
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // Hash results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] hash_value
  output logic [31:0] m_axis_tdata
);
  import mwh_pkg::*;

  logic [31:0] seed;
  logic        push;
  logic        pop;
  qitem_t      push_item;
  qitem_t      pop_item;
  qstat_t      qstat;

  // Seed register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  mwh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .seed         (seed),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .data_word    (s_axis_tdata[31:0]),
    .valid_bytes  (s_axis_tdata[34:32]),
    .first_of_key (s_axis_tuser),
    .last_of_key  (s_axis_tlast),
    .key_length   (s_axis_tdata[66:35]),
    .qstat        (qstat),
    .push         (push),
    .push_item    (push_item)
  );

  mwh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  mwh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .hash_value (m_axis_tdata)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("push into full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A push into an empty queue leaves it non-empty in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (push && qstat.empty) |=> !qstat.empty)
    else $error("queue lost a word");

  // No result is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
